// ===== rtl/aldb_pkg.sv =====
// aldb_pkg: shared types and constants for the ladder button decoder
// no dependencies
package aldb_pkg;

  localparam int LvlW = 12;
  localparam int TimeW = 32;

  // event kind codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvShort = 2'd1;
  localparam logic [1:0] EvLong  = 2'd2;

  // register indexes
  localparam logic [2:0] RegB1Lo   = 3'd0;
  localparam logic [2:0] RegB1Hi   = 3'd1;
  localparam logic [2:0] RegB2Lo   = 3'd2;
  localparam logic [2:0] RegB2Hi   = 3'd3;
  localparam logic [2:0] RegB3Lo   = 3'd4;
  localparam logic [2:0] RegB3Hi   = 3'd5;
  localparam logic [2:0] RegIdle   = 3'd6;
  localparam logic [2:0] RegLcMask = 3'd7;

  // configuration bundle
  typedef struct packed {
    logic [11:0] b1_lo;
    logic [11:0] b1_hi;
    logic [11:0] b2_lo;
    logic [11:0] b2_hi;
    logic [11:0] b3_lo;
    logic [11:0] b3_hi;
    logic [12:0] idle;
    logic [2:0]  lc_mask;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] now_ms;
    logic [11:0] adc_level;
    logic [1:0]  raw_btn;
    logic        cal_end;
    logic        busy;
  } item_t;

  // result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  button;
    logic [11:0] level;
  } res_t;

  // ladder classification
  function automatic logic [1:0] classify(input logic [11:0] lvl, input cfg_t c);
    logic [1:0] r;
    r = 2'd0;
    if ({1'b0, lvl} >= c.idle) r = 2'd0;
    else if (lvl >= c.b1_lo && lvl <= c.b1_hi) r = 2'd1;
    else if (lvl >= c.b2_lo && lvl <= c.b2_hi) r = 2'd2;
    else if (lvl >= c.b3_lo && lvl <= c.b3_hi) r = 2'd3;
    return r;
  endfunction

endpackage

// ===== rtl/aldb_front.sv =====
// aldb_front: accepts items, classifies the raw level, flags calibration end
// depends on aldb_pkg
module aldb_front (
  input  logic             clk,
  input  logic             rst,
  input  aldb_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  logic [31:0]      now_ms,
  input  logic [11:0]      adc_level,
  input  logic             calib_busy,
  output aldb_pkg::item_t  item,
  output logic             item_valid,
  input  logic             item_ready
);

  logic calib_prev;
  logic take;

  assign take = in_valid;

  // calibration edge tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_prev <= 1'b0;
    end else if (take) begin
      calib_prev <= calib_busy;
    end
  end

  // one-entry register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.now_ms    <= now_ms;
      item.adc_level <= adc_level;
      item.raw_btn   <= aldb_pkg::classify(adc_level, cfg);
      item.cal_end   <= !calib_busy && calib_prev;
      item.busy      <= calib_busy;
    end
  end

endmodule

// ===== rtl/aldb_queue.sv =====
// aldb_queue: small fifo of generic width
// no package dependency
module aldb_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full  = (cnt == (AW+1)'(Depth));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) begin
        wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      end
      if (rd && !empty) begin
        rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

// ===== rtl/aldb_back.sv =====
// aldb_back: filter, debounce and press timing, one item at a time
// depends on aldb_pkg
module aldb_back #(
  parameter int WindowDepth = 5,
  parameter int SamplePeriodMs = 50,
  parameter int DebounceMs = 50,
  parameter int LongHoldMs = 2000,
  parameter int SettleMs = 150,
  parameter int JumpCounts = 100
) (
  input  logic            clk,
  input  logic            rst,
  input  aldb_pkg::cfg_t  cfg,
  input  aldb_pkg::item_t item,
  input  logic            item_empty,
  output logic            item_pop,
  output aldb_pkg::res_t  res,
  output logic            res_push,
  input  logic            res_full
);

  localparam int IW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int SW = 12 + $clog2(WindowDepth + 1);
  // shift wide enough that the rounded-up reciprocal gives an exact floor
  localparam int MulW = SW + 4;
  // reciprocal for divide by the window depth
  localparam int unsigned Recip = ((1 << MulW) + WindowDepth - 1) / WindowDepth;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  logic [11:0] win [WindowDepth];
  logic [IW-1:0] widx;
  logic [11:0] avg_level, stable_level;
  logic [31:0] stable_since, last_sample_time, change_time, press_start, release_start;
  logic [1:0] held_button, debounced_button;
  logic suppressed;

  // per-item working registers
  logic [SW-1:0] sum;
  logic [IW-1:0] sidx;
  logic [SW+MulW-1:0] prod;

  // early checks on the head item
  logic [31:0] now;
  logic [11:0] raw;
  logic [1:0] rbtn;
  assign now  = item.now_ms;
  assign raw  = item.adc_level;
  assign rbtn = item.raw_btn;

  logic [31:0] ls_eff;
  logic [31:0] rs_pre;
  logic [1:0]  held_pre;
  logic [31:0] ct_pre, ps_pre;
  logic [1:0]  deb_pre;
  logic        sup_pre;

  // calibration end handling folded in front of the rest
  always_comb begin
    ls_eff   = last_sample_time;
    rs_pre   = release_start;
    held_pre = held_button;
    ct_pre   = change_time;
    ps_pre   = press_start;
    deb_pre  = debounced_button;
    sup_pre  = suppressed;
    if (item.cal_end) begin
      sup_pre  = 1'b1;
      held_pre = 2'd0;
      deb_pre  = 2'd0;
      ps_pre   = '0;
      rs_pre   = '0;
      ct_pre   = now;
    end
  end

  logic early;
  assign early = (now - ls_eff) < 32'(SamplePeriodMs);

  logic do_fill;
  logic [1:0] avg_btn;
  assign avg_btn = aldb_pkg::classify(avg_level, cfg);
  assign do_fill = !sup_pre && (rbtn != avg_btn);

  // release bookkeeping before the window update
  logic [1:0]  held_a;
  logic [31:0] ct_a, ps_a, rs_a;
  always_comb begin
    held_a = held_pre;
    ct_a   = ct_pre;
    ps_a   = ps_pre;
    rs_a   = rs_pre;
    if (do_fill) begin
      if (rs_a != '0) begin
        if (rbtn != 2'd0 && (now - rs_a) >= 32'(DebounceMs)) begin
          held_a = 2'd0;
          ct_a   = now;
          ps_a   = '0;
        end
        rs_a = '0;
      end
      if (held_a != 2'd0 && rbtn == 2'd0) rs_a = now;
    end
    if (rs_a != '0 && (now - rs_a) >= 32'(DebounceMs)) begin
      held_a = 2'd0;
      ct_a   = now;
      ps_a   = '0;
      rs_a   = '0;
    end
  end

  // final stage decisions
  logic [1:0] ek, eb, deb_n;
  logic [31:0] ps_n;
  logic long_hit, consume;
  always_comb begin
    ek = aldb_pkg::EvNone;
    eb = 2'd0;
    deb_n = debounced_button;
    ps_n = press_start;
    long_hit = held_button != 2'd0 && press_start != '0 &&
               (now - press_start) >= 32'(LongHoldMs);
    consume = 1'b0;
    if (long_hit) begin
      ps_n = '0;
      ek = aldb_pkg::EvLong;
      eb = held_button;
      consume = cfg.lc_mask[held_button - 2'd1];
    end
    if (!consume && debounced_button != held_button &&
        (now - change_time) >= 32'(DebounceMs)) begin
      deb_n = held_button;
      if (held_button != 2'd0 && ek == aldb_pkg::EvNone) begin
        ek = aldb_pkg::EvShort;
        eb = held_button;
      end
    end
  end

  // a new item starts only once the previous result has landed in the queue
  logic fast_pop;
  assign fast_pop = (state == S_IDLE) && !item_empty && !res_full && !res_push &&
                    (item.busy || early || sup_pre);
  logic start_work;
  assign start_work = (state == S_IDLE) && !item_empty && !res_full && !res_push &&
                      !item.busy && !early && !sup_pre;

  // the head item stays in place until its result is decided
  assign item_pop = fast_pop || (state == S_FIN);

  always_ff @(posedge clk) begin
    res_push <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < WindowDepth; i++) win[i] <= '0;
      widx <= '0;
      avg_level <= '0;
      stable_level <= '0;
      stable_since <= '0;
      last_sample_time <= '0;
      change_time <= '0;
      press_start <= '0;
      release_start <= '0;
      held_button <= 2'd0;
      debounced_button <= 2'd0;
      suppressed <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fast_pop) begin
            // items finished straight from idle, without the window sum
            res_push <= 1'b1;
            res.kind <= aldb_pkg::EvNone;
            res.button <= 2'd0;
            res.level <= avg_level;
            if (!item.busy) begin
              release_start <= rs_pre;
              held_button <= held_pre;
              change_time <= ct_pre;
              press_start <= ps_pre;
              debounced_button <= deb_pre;
              suppressed <= sup_pre;
              if (!early) begin
                last_sample_time <= now;
                if (rbtn == 2'd0) begin
                  if (rs_pre == '0) begin
                    release_start <= now;
                  end else if ((now - rs_pre) >= 32'(DebounceMs)) begin
                    suppressed <= 1'b0;
                    release_start <= '0;
                    for (int i = 0; i < WindowDepth; i++) win[i] <= raw;
                    widx <= '0;
                    avg_level <= raw;
                    res.level <= raw;
                    stable_level <= raw;
                    stable_since <= now;
                  end
                end else begin
                  release_start <= '0;
                end
              end
            end
          end else if (start_work) begin
            last_sample_time <= now;
            suppressed <= sup_pre;
            debounced_button <= deb_pre;
            held_button <= held_a;
            change_time <= ct_a;
            press_start <= ps_a;
            release_start <= rs_a;
            if (do_fill) begin
              stable_since <= now;
              for (int i = 0; i < WindowDepth; i++) win[i] <= raw;
              widx <= (WindowDepth > 1) ? IW'(1) : '0;
            end else begin
              win[widx] <= raw;
              widx <= (widx == IW'(WindowDepth-1)) ? '0 : widx + 1'b1;
            end
            sum <= '0;
            sidx <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // one window entry per cycle
          sum <= sum + SW'(win[sidx]);
          if (sidx == IW'(WindowDepth-1)) begin
            state <= S_DIV;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        S_DIV: begin
          prod <= (SW+MulW)'(sum) * (SW+MulW)'(Recip);
          state <= S_FIN;
        end
        S_FIN: begin
          logic [11:0] q;
          q = 12'(prod >> MulW);
          avg_level <= q;
          res.level <= q;
          res_push <= 1'b1;
          res.kind <= aldb_pkg::EvNone;
          res.button <= 2'd0;
          state <= S_IDLE;
          if (((q > stable_level) ? q - stable_level : stable_level - q) >
              12'(JumpCounts)) begin
            stable_level <= q;
            stable_since <= now;
            res.kind <= ek;
            res.button <= eb;
            debounced_button <= deb_n;
            press_start <= ps_n;
          end else if ((now - stable_since) < 32'(SettleMs)) begin
            res.kind <= ek;
            res.button <= eb;
            debounced_button <= deb_n;
            press_start <= ps_n;
          end else begin
            stable_level <= q;
            stable_since <= now;
            if (aldb_pkg::classify(q, cfg) != held_button) begin
              held_button <= aldb_pkg::classify(q, cfg);
              change_time <= now;
              press_start <= (aldb_pkg::classify(q, cfg) != 2'd0) ? now : '0;
            end else begin
              res.kind <= ek;
              res.button <= eb;
              debounced_button <= deb_n;
              press_start <= ps_n;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/adc_ladder_button_decoder_core.sv =====
// adc_ladder_button_decoder_core: top level of the ladder button decoder
// depends on aldb_pkg, aldb_front, aldb_queue, aldb_back
//
// channel  direction  handshake       payload
// input    in         push / full     now_ms, adc_level, calib_busy
// result   out        pop / empty     event_kind, event_button, filtered_level
// config   in         apb write/read  registers 0..7 at 4*i
//
// ignored or early samples are retired from idle: the item is popped and its result
// registered, and the next item waits while that result is written into the result queue
// a kept sample goes through start, the serial window sum, one multiply, finish and
// the result write
// rst is synchronous and restores register defaults and clears the control state
// front and back are parted by a small queue; a full result queue stalls the back
module adc_ladder_button_decoder_core #(
  parameter int WindowDepth = 5,
  parameter int SamplePeriodMs = 50,
  parameter int DebounceMs = 50,
  parameter int LongHoldMs = 2000,
  parameter int SettleMs = 150,
  parameter int JumpCounts = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] now_ms,
  input  logic [11:0] adc_level,
  input  logic        calib_busy,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind,
  output logic [1:0]  event_button,
  output logic [11:0] filtered_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  aldb_pkg::cfg_t cfg;
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b1_lo <= 12'd3100;
      cfg.b1_hi <= 12'd3520;
      cfg.b2_lo <= 12'd3520;
      cfg.b2_hi <= 12'd3880;
      cfg.b3_lo <= 12'd3880;
      cfg.b3_hi <= 12'd4095;
      cfg.idle  <= 13'd4096;
      cfg.lc_mask <= 3'd0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        aldb_pkg::RegB1Lo:   cfg.b1_lo <= pwdata[11:0];
        aldb_pkg::RegB1Hi:   cfg.b1_hi <= pwdata[11:0];
        aldb_pkg::RegB2Lo:   cfg.b2_lo <= pwdata[11:0];
        aldb_pkg::RegB2Hi:   cfg.b2_hi <= pwdata[11:0];
        aldb_pkg::RegB3Lo:   cfg.b3_lo <= pwdata[11:0];
        aldb_pkg::RegB3Hi:   cfg.b3_hi <= pwdata[11:0];
        aldb_pkg::RegIdle:   cfg.idle  <= pwdata[12:0];
        aldb_pkg::RegLcMask: cfg.lc_mask <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      aldb_pkg::RegB1Lo:   prdata = {20'd0, cfg.b1_lo};
      aldb_pkg::RegB1Hi:   prdata = {20'd0, cfg.b1_hi};
      aldb_pkg::RegB2Lo:   prdata = {20'd0, cfg.b2_lo};
      aldb_pkg::RegB2Hi:   prdata = {20'd0, cfg.b2_hi};
      aldb_pkg::RegB3Lo:   prdata = {20'd0, cfg.b3_lo};
      aldb_pkg::RegB3Hi:   prdata = {20'd0, cfg.b3_hi};
      aldb_pkg::RegIdle:   prdata = {19'd0, cfg.idle};
      aldb_pkg::RegLcMask: prdata = {29'd0, cfg.lc_mask};
      default:             prdata = '0;
    endcase
  end

  // front part
  aldb_pkg::item_t fitem;
  logic fvalid, qfull;
  assign full = fvalid && qfull;
  aldb_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(push && !full),
    .now_ms(now_ms), .adc_level(adc_level), .calib_busy(calib_busy),
    .item(fitem), .item_valid(fvalid), .item_ready(!qfull)
  );

  // queue between front and back
  aldb_pkg::item_t bitem;
  logic bempty, bpop;
  aldb_queue #(.Width($bits(aldb_pkg::item_t)), .Depth(4)) u_iq (
    .clk(clk), .rst(rst),
    .wr(fvalid), .wdata(fitem), .full(qfull),
    .rd(bpop), .rdata(bitem), .empty(bempty)
  );

  // back part
  aldb_pkg::res_t bres;
  logic rpush, rfull;
  logic fin;
  aldb_back #(
    .WindowDepth(WindowDepth), .SamplePeriodMs(SamplePeriodMs),
    .DebounceMs(DebounceMs), .LongHoldMs(LongHoldMs),
    .SettleMs(SettleMs), .JumpCounts(JumpCounts)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .item(bitem), .item_empty(bempty), .item_pop(fin),
    .res(bres), .res_push(rpush), .res_full(rfull)
  );

  // the back consumes the head item when it has decided its result
  assign bpop = fin;

  // result queue, deep enough for in-flight results
  aldb_pkg::res_t ores;
  logic rq_full;
  aldb_queue #(.Width($bits(aldb_pkg::res_t)), .Depth(4)) u_rq (
    .clk(clk), .rst(rst),
    .wr(rpush), .wdata(bres), .full(rq_full),
    .rd(pop), .rdata(ores), .empty(empty)
  );
  assign rfull = rq_full;

  assign event_kind     = ores.kind;
  assign event_button   = ores.button;
  assign filtered_level = ores.level;

endmodule

// ===== tb/testbench.sv =====
// testbench for adc_ladder_button_decoder_core: queue-style item and result
// ports, apb configuration, a class that predicts button events and checks them
// depends on aldb_pkg and the rtl of adc_ladder_button_decoder_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 30;
  localparam int StallLimit = 20000;

  // predicts events from accepted samples and checks popped results
  class button_event_predictor;
    int unsigned lo1, hi1, lo2, hi2, lo3, hi3, idle_lvl, lc_mask;
    int unsigned win [5];
    int unsigned win_idx, avg, stable_lvl;
    bit [31:0] stable_since, last_time, change_time, press_start, release_start;
    int unsigned held, debounced;
    bit calib_prev, suppressed;
    int unsigned ev_kind, ev_btn;
    logic [15:0] expected_events [$];
    int unsigned errors;

    function new();
      lo1 = 3100; hi1 = 3520; lo2 = 3520; hi2 = 3880; lo3 = 3880; hi3 = 4095;
      idle_lvl = 4096; lc_mask = 0;
      foreach (win[i]) win[i] = 0;
      win_idx = 0; avg = 0; stable_lvl = 0; stable_since = 0; last_time = 0;
      held = 0; debounced = 0; change_time = 0; press_start = 0; release_start = 0;
      calib_prev = 0; suppressed = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned v);
      case (idx)
        aldb_pkg::RegB1Lo:   lo1 = v & 12'hFFF;
        aldb_pkg::RegB1Hi:   hi1 = v & 12'hFFF;
        aldb_pkg::RegB2Lo:   lo2 = v & 12'hFFF;
        aldb_pkg::RegB2Hi:   hi2 = v & 12'hFFF;
        aldb_pkg::RegB3Lo:   lo3 = v & 12'hFFF;
        aldb_pkg::RegB3Hi:   hi3 = v & 12'hFFF;
        aldb_pkg::RegIdle:   idle_lvl = v & 13'h1FFF;
        aldb_pkg::RegLcMask: lc_mask = v & 3'h7;
        default: ;
      endcase
    endfunction

    function int unsigned button_of(int unsigned lvl);
      if (lvl >= idle_lvl) return 0;
      if (lvl >= lo1 && lvl <= hi1) return 1;
      if (lvl >= lo2 && lvl <= hi2) return 2;
      if (lvl >= lo3 && lvl <= hi3) return 3;
      return 0;
    endfunction

    function void refill(int unsigned lvl);
      foreach (win[i]) win[i] = lvl;
      win_idx = 0;
    endfunction

    function void release_now(bit [31:0] t);
      held = 0;
      change_time = t;
      press_start = 0;
    endfunction

    // long press first; a consuming long press skips the short check
    function void update_events(bit [31:0] t);
      bit [31:0] dt;
      dt = t - press_start;
      if (held != 0 && press_start != 0 && dt >= 2000) begin
        press_start = 0;
        ev_kind = aldb_pkg::EvLong;
        ev_btn = held;
        if ((lc_mask >> (held - 1)) & 1) return;
      end
      dt = t - change_time;
      if (debounced != held && dt >= 50) begin
        debounced = held;
        if (held != 0 && ev_kind == aldb_pkg::EvNone) begin
          ev_kind = aldb_pkg::EvShort;
          ev_btn = held;
        end
      end
    endfunction

    function void advance(bit [31:0] t, int unsigned raw, bit busy);
      int unsigned raw_btn, sum, diff, det;
      bit [31:0] dt;
      // calibration end
      if (!busy && calib_prev) begin
        suppressed = 1;
        held = 0;
        debounced = 0;
        press_start = 0;
        release_start = 0;
        change_time = t;
      end
      calib_prev = busy;
      if (busy) return;
      dt = t - last_time;
      if (dt < 50) return;
      last_time = t;
      // suppressed: only wait for a confirmed release
      if (suppressed) begin
        if (button_of(raw) == 0) begin
          dt = t - release_start;
          if (release_start == 0) release_start = t;
          else if (dt >= 50) begin
            suppressed = 0;
            release_start = 0;
            refill(raw);
            avg = raw;
            stable_lvl = raw;
            stable_since = t;
          end
        end else release_start = 0;
        return;
      end
      // range change refills the window
      raw_btn = button_of(raw);
      if (raw_btn != button_of(avg)) begin
        refill(raw);
        stable_since = t;
        if (release_start != 0) begin
          dt = t - release_start;
          if (raw_btn != 0 && dt >= 50) release_now(t);
          release_start = 0;
        end
        if (held != 0 && raw_btn == 0) release_start = t;
      end
      dt = t - release_start;
      if (release_start != 0 && dt >= 50) begin
        release_now(t);
        release_start = 0;
      end
      // moving average
      if (win_idx >= 5) win_idx = 0;
      win[win_idx] = raw;
      win_idx = (win_idx + 1) % 5;
      sum = 0;
      foreach (win[i]) sum += win[i];
      avg = (sum / 5) & 12'hFFF;
      diff = avg > stable_lvl ? avg - stable_lvl : stable_lvl - avg;
      if (diff > 100) begin
        stable_lvl = avg;
        stable_since = t;
        update_events(t);
        return;
      end
      dt = t - stable_since;
      if (dt < 150) begin
        update_events(t);
        return;
      end
      stable_lvl = avg;
      stable_since = t;
      det = button_of(avg);
      if (det != held) begin
        held = det;
        change_time = t;
        press_start = det != 0 ? t : 0;
        return;
      end
      update_events(t);
    endfunction

    function void note_sample(bit [31:0] t, int unsigned raw, bit busy);
      logic [1:0] k, b;
      logic [11:0] l;
      ev_kind = aldb_pkg::EvNone;
      ev_btn = 0;
      advance(t, raw, busy);
      k = ev_kind[1:0];
      b = ev_btn[1:0];
      l = avg[11:0];
      expected_events.push_back({k, b, l});
    endfunction

    function void check_event(logic [1:0] k, logic [1:0] b, logic [11:0] l);
      logic [15:0] e;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result kind %0d button %0d level %0d", $time, k, b, l);
        errors++;
        return;
      end
      e = expected_events.pop_front();
      if (k !== e[15:14]) begin
        $display("%0t: event_kind expected %0d got %0d", $time, e[15:14], k);
        errors++;
      end
      if (b !== e[13:12]) begin
        $display("%0t: event_button expected %0d got %0d", $time, e[13:12], b);
        errors++;
      end
      if (l !== e[11:0]) begin
        $display("%0t: filtered_level expected %0d got %0d", $time, e[11:0], l);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, push, full, calib_busy, empty, pop;
  logic [31:0] now_ms, pwdata, prdata;
  logic [11:0] adc_level, filtered_level;
  logic [1:0] event_kind, event_button;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;

  button_event_predictor events_model;
  int unsigned send_idle_pct, pop_stall_pct;
  int unsigned quiet_cycles;
  bit [31:0] clock_ms;

  adc_ladder_button_decoder_core DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .now_ms(now_ms),
    .adc_level(adc_level), .calib_busy(calib_busy), .empty(empty), .pop(pop),
    .event_kind(event_kind), .event_button(event_button),
    .filtered_level(filtered_level), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, check on accept
  always @(negedge clk) pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    if (!rst && pop && !empty) events_model.check_event(event_kind, event_button, filtered_level);
  end

  // watchdog on cycles with no accepted item or result
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    events_model.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic write_ranges(int unsigned a, int unsigned b, int unsigned c,
                              int unsigned d, int unsigned e, int unsigned f,
                              int unsigned idle, int unsigned mask);
    write_reg(aldb_pkg::RegB1Lo, a); write_reg(aldb_pkg::RegB1Hi, b);
    write_reg(aldb_pkg::RegB2Lo, c); write_reg(aldb_pkg::RegB2Hi, d);
    write_reg(aldb_pkg::RegB3Lo, e); write_reg(aldb_pkg::RegB3Hi, f);
    write_reg(aldb_pkg::RegIdle, idle); write_reg(aldb_pkg::RegLcMask, mask);
  endtask

  task automatic send_sample(bit [31:0] t, int unsigned lvl, bit busy);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1; now_ms = t; adc_level = lvl[11:0]; calib_busy = busy;
    @(posedge clk);
    while (full) @(posedge clk);
    events_model.note_sample(t, lvl, busy);
  endtask

  // idle the input and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (events_model.expected_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // a level inside button b's window, or anything if the window is empty
  function automatic int unsigned press_level(int unsigned b);
    int unsigned lo, hi;
    lo = b == 1 ? events_model.lo1 : b == 2 ? events_model.lo2 : events_model.lo3;
    hi = b == 1 ? events_model.hi1 : b == 2 ? events_model.hi2 : events_model.hi3;
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom_range(4095);
  endfunction

  function automatic int unsigned release_level();
    int unsigned lvl;
    lvl = $urandom_range(4095);
    for (int i = 0; i < 8; i++) begin
      if (events_model.button_of(lvl) == 0) return lvl;
      lvl = $urandom_range(4095);
    end
    return lvl;
  endfunction

  function automatic bit [31:0] next_time();
    if ($urandom_range(19) == 0) return clock_ms + $urandom_range(49);
    return clock_ms + 50 + $urandom_range(12);
  endfunction

  // well-formed press and release sequences with some noise and calibration
  task automatic random_samples(int n);
    int sent, hold, lvl, b, choice;
    sent = 0;
    while (sent < n) begin
      choice = $urandom_range(9);
      if (choice < 6) begin
        // press, hold with jitter, release
        b = $urandom_range(3, 1);
        hold = $urandom_range(3) == 0 ? $urandom_range(55, 38) : $urandom_range(12, 2);
        lvl = press_level(b);
        repeat (hold) begin
          clock_ms = next_time();
          send_sample(clock_ms, $urandom_range(5) == 0 ?
                      press_level(b) : lvl, 1'b0);
          sent++;
        end
        repeat ($urandom_range(6, 1)) begin
          clock_ms = next_time();
          send_sample(clock_ms, release_level(), 1'b0);
          sent++;
        end
      end else if (choice < 8) begin
        // noise, sometimes with a jump in time
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(9) == 0) clock_ms = $urandom();
          else if ($urandom_range(9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(120);
          else clock_ms = clock_ms + $urandom_range(200);
          send_sample(clock_ms, $urandom_range(4095), $urandom_range(15) == 0);
          sent++;
        end
      end else begin
        // calibration, then release or a held button
        repeat ($urandom_range(4, 1)) begin
          clock_ms = next_time();
          send_sample(clock_ms, $urandom_range(4095), 1'b1);
          sent++;
        end
        b = $urandom_range(3, 1);
        repeat ($urandom_range(6, 1)) begin
          clock_ms = next_time();
          send_sample(clock_ms, $urandom_range(2) == 0 ?
                      press_level(b) : release_level(), 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    events_model = new();
    rst = 1'b1; push = 1'b0; pop = 1'b0; now_ms = '0; adc_level = '0;
    calib_busy = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; quiet_cycles = 0; clock_ms = 0;
    send_idle_pct = 0; pop_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, time zero, early sample, calibration, idle level
    send_sample(32'd0, 12'd0, 1'b0);
    send_sample(32'd50, 12'd4095, 1'b0);
    send_sample(32'd60, 12'd3300, 1'b0);
    send_sample(32'd100, 12'd3300, 1'b0);
    send_sample(32'd150, 12'd3300, 1'b0);
    send_sample(32'd200, 12'd3300, 1'b0);
    send_sample(32'd250, 12'd3300, 1'b0);
    send_sample(32'd300, 12'd3300, 1'b0);
    send_sample(32'd350, 12'd3300, 1'b0);
    send_sample(32'd400, 12'd1000, 1'b0);
    send_sample(32'd450, 12'd1000, 1'b0);
    send_sample(32'd500, 12'd1000, 1'b1);
    send_sample(32'd550, 12'd3700, 1'b0);
    send_sample(32'd600, 12'd0, 1'b0);
    send_sample(32'd650, 12'd0, 1'b0);
    send_sample(32'd700, 12'd0, 1'b0);
    send_sample(32'hFFFF_FFC0, 12'd3950, 1'b0);
    send_sample(32'hFFFF_FFFF, 12'd3950, 1'b0);
    send_sample(32'd0, 12'd3950, 1'b0);
    send_sample(32'd50, 12'd3950, 1'b0);
    send_sample(32'd100, 12'd3950, 1'b0);
    send_sample(32'd150, 12'd3950, 1'b0);
    send_sample(32'hFFFF_FFFF, 12'hAAA, 1'b0);
    send_sample(32'h5555_5555, 12'h555, 1'b0);
    clock_ms = 32'h5555_5555;
    random_samples(350);
    drain();

    // long press consumes the press for every button, sender mostly idle
    write_ranges(3100, 3520, 3520, 3880, 3880, 4095, 4096, 7);
    send_idle_pct = 83;
    random_samples(370);
    drain();

    // shifted windows and idle level, receiver mostly stalled
    write_ranges(500, 1200, 1300, 2100, 2200, 3000, 3500, 2);
    send_idle_pct = 0; pop_stall_pct = 83;
    random_samples(370);
    drain();

    // extremes: overlapping full-range windows, widest idle level
    write_ranges(0, 4095, 0, 4095, 4095, 0, 8191, 5);
    send_idle_pct = 9; pop_stall_pct = 9;
    random_samples(180);
    drain();
    write_ranges(4095, 4095, 0, 0, 2000, 4095, 0, 0);
    random_samples(60);
    drain();

    // random windows, no idling
    write_ranges($urandom_range(1500), $urandom_range(2500, 1500),
                 $urandom_range(2600, 2400), $urandom_range(3300, 2600),
                 $urandom_range(3400, 3300), $urandom_range(4095, 3400),
                 $urandom_range(4096, 3800), $urandom_range(7));
    send_idle_pct = 0; pop_stall_pct = 0;
    random_samples(420);
    drain();

    if (events_model.errors == 0 && events_model.expected_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
